// ===== rtl/core/tpie_pkg.sv =====
// Shared types and codes for the tensor pad index engine.
// No dependencies; imported by the controller, datapath and top level.
package tpie_pkg;

	localparam int TDATA_IN_W  = 56;
	localparam int TDATA_OUT_W = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_LEFT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTER_PAD  = 3'd7;

	// pad modes
	localparam logic [1:0] MODE_CONSTANT  = 2'd0;
	localparam logic [1:0] MODE_REFLECT   = 2'd1;
	localparam logic [1:0] MODE_SYMMETRIC = 2'd2;
	localparam logic [1:0] MODE_UNSUP     = 2'd3;

	// result status
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
	localparam logic [1:0] ST_OUTSIDE     = 2'd2;

	// input operation
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	typedef struct packed {
		logic load_wr;   // write the accepted load into the frame store
		logic capture;   // latch the accepted fetch position
		logic map_en;    // register the mapped source position and status
		logic rd_en;     // issue the frame store read
		logic out_load;  // load the output register
	} tpie_cmd_t;

	typedef struct packed {
		logic need_read; // mapped fetch hits a stored word
	} tpie_stat_t;

endpackage

// ===== rtl/core/tpie_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/tpie_ctrl.sv =====
// Sequencing FSM of the pad index engine: input handshake, fetch steps, output valid.
// Depends on tpie_pkg.
module tpie_ctrl
	import tpie_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic       s_op,
	output logic       m_tvalid,
	input  logic       m_tready,
	output tpie_cmd_t  cmd,
	input  tpie_stat_t stat
);

	typedef enum logic [1:0] {
		IDLE,
		MAP,
		RD,
		DONE
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   in_xfer;
	logic   out_free;

	assign s_tready = (state_q == IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd          = '0;
		cmd.load_wr  = in_xfer && (s_op == OP_LOAD);
		cmd.capture  = in_xfer && (s_op == OP_FETCH);
		cmd.map_en   = (state_q == MAP);
		cmd.rd_en    = (state_q == RD);
		cmd.out_load = (state_q == DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (cmd.capture) begin
						state_q <= MAP;
					end
				end
				MAP: begin
					// errors and fill words skip the store read
					state_q <= stat.need_read ? RD : DONE;
				end
				RD: begin
					state_q <= DONE;
				end
				DONE: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/tpie_datapath.sv =====
// Datapath of the pad index engine: config registers, coordinate fold,
// frame store addressing and output register. Depends on tpie_pkg and tpie_ram.
module tpie_datapath
	import tpie_pkg::*;
#(
	parameter int MAX_HEIGHT   = 64,
	parameter int MAX_WIDTH    = 64,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [7:0]            row_index,
	input  logic [7:0]            col_index,
	input  logic [1:0]            channel_index,
	input  logic [31:0]           element_word,
	input  tpie_cmd_t             cmd,
	output tpie_stat_t            stat,
	output logic [31:0]           out_value,
	output logic [1:0]            out_status
);

	localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	typedef struct packed {
		logic               ok;
		logic signed [10:0] q;
	} fold_t;

	// one reflection about the frame edges; ok is low if still outside
	function automatic fold_t fold(input logic signed [10:0] p,
			input logic signed [10:0] n, input logic sym);
		fold_t              r;
		logic signed [10:0] q;
		logic signed [10:0] m;
		if (p < 0) begin
			q = sym ? (-p - 11'sd1) : -p;
		end else begin
			q = p;
		end
		m = (n <<< 1) - (sym ? 11'sd1 : 11'sd2) - q;
		if (m < q) begin
			q = m;
		end
		r.ok = (q >= 0) && (q < n);
		r.q  = q;
		return r;
	endfunction

	// configuration
	logic [1:0]  pad_mode_q;
	logic [6:0]  pad_top_q;
	logic [6:0]  pad_left_q;
	logic [6:0]  in_height_q;
	logic [6:0]  in_width_q;
	logic [2:0]  channels_q;
	logic [31:0] fill_value_q;
	logic        outer_pad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_mode_q   <= MODE_CONSTANT;
			pad_top_q    <= 7'd0;
			pad_left_q   <= 7'd0;
			in_height_q  <= 7'd64;
			in_width_q   <= 7'd64;
			channels_q   <= 3'd4;
			fill_value_q <= 32'd0;
			outer_pad_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PAD_MODE:   pad_mode_q   <= cfg_wdata[1:0];
				CFG_PAD_TOP:    pad_top_q    <= cfg_wdata[6:0];
				CFG_PAD_LEFT:   pad_left_q   <= cfg_wdata[6:0];
				CFG_IN_HEIGHT:  in_height_q  <= cfg_wdata[6:0];
				CFG_IN_WIDTH:   in_width_q   <= cfg_wdata[6:0];
				CFG_CHANNELS:   channels_q   <= cfg_wdata[2:0];
				CFG_FILL_VALUE: fill_value_q <= cfg_wdata[31:0];
				CFG_OUTER_PAD:  outer_pad_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// captured fetch position
	logic [7:0] row_q;
	logic [7:0] col_q;
	logic [1:0] ch_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q <= row_index;
			col_q <= col_index;
			ch_q  <= channel_index;
		end
	end

	// index map
	logic               unsup;
	logic signed [10:0] h;
	logic signed [10:0] w;
	logic signed [10:0] nh;
	logic signed [10:0] nw;
	logic               sym;
	fold_t              fh;
	fold_t              fw;
	logic               in_frame;
	logic [1:0]         map_status;
	logic               map_fill;

	always_comb begin
		unsup = outer_pad_q || (pad_mode_q == MODE_UNSUP) ||
			(in_height_q == 7'd0) || (32'(in_height_q) > 32'(MAX_HEIGHT)) ||
			(in_width_q == 7'd0) || (32'(in_width_q) > 32'(MAX_WIDTH)) ||
			(channels_q == 3'd0) || (32'(channels_q) > 32'(MAX_CHANNELS));
		h   = $signed({3'b000, row_q}) - $signed({4'b0000, pad_top_q});
		w   = $signed({3'b000, col_q}) - $signed({4'b0000, pad_left_q});
		nh  = $signed({4'b0000, in_height_q});
		nw  = $signed({4'b0000, in_width_q});
		sym = (pad_mode_q == MODE_SYMMETRIC);
		fh  = fold(h, nh, sym);
		fw  = fold(w, nw, sym);
		in_frame = (h >= 0) && (h < nh) && (w >= 0) && (w < nw);
		map_fill = 1'b0;
		if (unsup) begin
			map_status = ST_UNSUPPORTED;
		end else if ({1'b0, ch_q} >= channels_q) begin
			map_status = ST_OUTSIDE;
		end else if (pad_mode_q == MODE_CONSTANT) begin
			map_status = ST_OK;
			map_fill   = !in_frame;
		end else if (fh.ok && fw.ok) begin
			map_status = ST_OK;
		end else begin
			map_status = ST_OUTSIDE;
		end
	end

	assign stat.need_read = (map_status == ST_OK) && !map_fill;

	logic [1:0]    status_q;
	logic          fill_q;
	logic [RW-1:0] src_row_q;
	logic [CW-1:0] src_col_q;

	always_ff @(posedge clk) begin
		if (cmd.map_en) begin
			status_q  <= map_status;
			fill_q    <= map_fill;
			src_row_q <= (pad_mode_q == MODE_CONSTANT) ? h[RW-1:0] : fh.q[RW-1:0];
			src_col_q <= (pad_mode_q == MODE_CONSTANT) ? w[CW-1:0] : fw.q[CW-1:0];
		end
	end

	// frame store
	logic [AW-1:0] waddr;
	logic          wr_en;
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;

	assign wr_en = cmd.load_wr && (32'(row_index) < 32'(MAX_HEIGHT)) &&
		(32'(col_index) < 32'(MAX_WIDTH)) && (32'(channel_index) < 32'(MAX_CHANNELS));
	assign waddr = AW'((32'(row_index) * 32'(MAX_WIDTH) + 32'(col_index)) *
		32'(MAX_CHANNELS) + 32'(channel_index));
	assign raddr = AW'((32'(src_row_q) * 32'(MAX_WIDTH) + 32'(src_col_q)) *
		32'(MAX_CHANNELS) + 32'(ch_q));

	tpie_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_frame_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(element_word),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	// output register
	logic [31:0] out_value_q;
	logic [1:0]  out_status_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= status_q;
			if (status_q != ST_OK) begin
				out_value_q <= 32'd0;
			end else if (fill_q) begin
				out_value_q <= fill_value_q;
			end else begin
				out_value_q <= rdata;
			end
		end
	end

	assign out_value  = out_value_q;
	assign out_status = out_status_q;

endmodule

// ===== rtl/core/tensor_pad_index_engine.sv =====
// Pads one height-width-channel frame on height and width (constant, reflect,
// symmetric). A load transfer writes one word into the frame store, if its position
// lies within the store, and leaves the engine ready. A fetch transfer steps through
// transfer, position map, store read and output load when it reads the store, and
// skips the store read when it returns the fill word or an error status; the steps
// are set by the registered fold stage and the registered read port of the frame
// store. After the output load the engine is ready again, even while the result
// still waits in the output register, but the output load of a following
// fetch waits until that result has been taken. Frame store contents are undefined
// until loaded. Depends on tpie_pkg, tpie_ctrl, tpie_datapath and tpie_ram.
module tensor_pad_index_engine
	import tpie_pkg::*;
#(
	parameter int MAX_HEIGHT   = 64,
	parameter int MAX_WIDTH    = 64,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// row_index[7:0], col_index[15:8], channel_index[17:16], element_word[49:18], zero
	input  logic [TDATA_IN_W-1:0]  s_tdata,
	input  logic [0:0]             s_tuser,  // operation[0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,  // out_value[31:0]
	output logic [1:0]             m_tuser   // status[1:0]
);

	tpie_cmd_t  cmd;
	tpie_stat_t stat;

	tpie_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_op    (s_tuser[0]),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.stat    (stat)
	);

	tpie_datapath #(
		.MAX_HEIGHT  (MAX_HEIGHT),
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.row_index    (s_tdata[7:0]),
		.col_index    (s_tdata[15:8]),
		.channel_index(s_tdata[17:16]),
		.element_word (s_tdata[49:18]),
		.cmd          (cmd),
		.stat         (stat),
		.out_value    (m_tdata),
		.out_status   (m_tuser)
	);

endmodule

// ===== bench/tensor_pad_index_engine_tb.sv =====
// Self-checking bench for tensor_pad_index_engine: loads frames, fetches padded
// positions in every mode and compares each result with an in-bench prediction.
// Depends on tpie_pkg and the tensor_pad_index_engine RTL.
module tensor_pad_index_engine_tb;
	import tpie_pkg::*;

	localparam int MAX_H = 64;
	localparam int MAX_W = 64;
	localparam int MAX_C = 4;
	localparam int STORE_WORDS = MAX_H * MAX_W * MAX_C;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		logic        op;
		logic [7:0]  row;
		logic [7:0]  col;
		logic [1:0]  chan;
		logic [31:0] word;
	} pad_item_t;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
	} pad_result_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [6:0]  top;
		logic [6:0]  left;
		logic [6:0]  height;
		logic [6:0]  width;
		logic [2:0]  chans;
		logic [31:0] fill;
		logic        outer;
	} pad_cfg_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// row_index[7:0], col_index[15:8], channel_index[17:16], element_word[49:18], zero
	logic [TDATA_IN_W-1:0]  s_tdata = '0;
	logic [0:0]             s_tuser = '0;   // operation[0]
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;        // out_value[31:0]
	logic [1:0]             m_tuser;        // status[1:0]

	tensor_pad_index_engine #(
		.MAX_HEIGHT(MAX_H),
		.MAX_WIDTH(MAX_W),
		.MAX_CHANNELS(MAX_C)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	pad_cfg_t    cur_cfg;
	logic [31:0] frame_words [0:STORE_WORDS-1];
	bit          queued_written [0:STORE_WORDS-1];
	pad_item_t   items_to_send [$];
	pad_result_t padded_words_due [$];
	pad_item_t   offered_item;
	int          items_queued = 0;
	int          mismatches = 0;
	int          send_gap = 0;
	int          send_gap_max = 3;
	int          recv_wait = 0;
	int          recv_gap_max = 3;
	int          hold_requests = 0;
	int          holds_served = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(12 * 600000);
		$display("Test completed with failures");
		$finish;
	end

	function automatic int store_index(input int r, input int c, input int ch);
		return (r * MAX_W + c) * MAX_C + ch;
	endfunction

	// one fold of a coordinate; reflect skips the edge, symmetric repeats it
	function automatic bit fold_coord(input int p, input int n, input bit sym, output int q);
		int f;
		if (sym) begin
			f = (p < 0) ? -p - 1 : p;
			if (2 * n - 1 - f < f) f = 2 * n - 1 - f;
		end else begin
			f = (p < 0) ? -p : p;
			if (2 * n - 2 - f < f) f = 2 * n - 2 - f;
		end
		q = f;
		return (f >= 0 && f < n);
	endfunction

	// maps a fetch to its status and, for a stored word, its store index
	function automatic void map_fetch(input pad_item_t it, output logic [1:0] st,
			output bit fill_hit, output int addr);
		int h, w, sh, sw, row_i, col_i, top_i, left_i, nh, nw;
		bit ok_h, ok_w;
		st = ST_OK;
		fill_hit = 1'b0;
		addr = 0;
		row_i = it.row;
		col_i = it.col;
		top_i = cur_cfg.top;
		left_i = cur_cfg.left;
		nh = cur_cfg.height;
		nw = cur_cfg.width;
		if (cur_cfg.outer || cur_cfg.mode == MODE_UNSUP || nh == 0 || nh > MAX_H ||
				nw == 0 || nw > MAX_W || cur_cfg.chans == 0 || cur_cfg.chans > MAX_C) begin
			st = ST_UNSUPPORTED;
		end else if (it.chan >= cur_cfg.chans) begin
			st = ST_OUTSIDE;
		end else begin
			h = row_i - top_i;
			w = col_i - left_i;
			if (cur_cfg.mode == MODE_CONSTANT) begin
				if (h < 0 || w < 0 || h >= nh || w >= nw)
					fill_hit = 1'b1;
				else
					addr = store_index(h, w, it.chan);
			end else begin
				ok_h = fold_coord(h, nh, cur_cfg.mode == MODE_SYMMETRIC, sh);
				ok_w = fold_coord(w, nw, cur_cfg.mode == MODE_SYMMETRIC, sw);
				if (ok_h && ok_w)
					addr = store_index(sh, sw, it.chan);
				else
					st = ST_OUTSIDE;
			end
		end
	endfunction

	// applies one accepted transfer: loads update the frame copy, fetches queue a result
	task automatic mirror_item(input pad_item_t it);
		logic [1:0] st;
		bit fill_hit;
		int addr;
		pad_result_t res;
		if (it.op == OP_LOAD) begin
			if (it.row < MAX_H && it.col < MAX_W && it.chan < MAX_C)
				frame_words[store_index(it.row, it.col, it.chan)] = it.word;
		end else begin
			map_fetch(it, st, fill_hit, addr);
			res.status = st;
			if (st != ST_OK)
				res.value = '0;
			else if (fill_hit)
				res.value = cur_cfg.fill;
			else
				res.value = frame_words[addr];
			padded_words_due.push_back(res);
		end
	endtask

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("ERROR at %0t: %s", $realtime, msg);
	endtask

	// sender: one item offered at a time, random gap after each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				mirror_item(offered_item);
				send_gap = $urandom_range(0, send_gap_max);
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (items_to_send.size() != 0) begin
					offered_item = items_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, offered_item.word, offered_item.chan,
						offered_item.col, offered_item.row};
					s_tuser <= offered_item.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result, stalls at random, honors long hold requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (padded_words_due.size() == 0) begin
					flag_error($sformatf("unexpected result value %h status %0d",
						m_tdata, m_tuser));
				end else begin
					if (m_tdata !== padded_words_due[0].value ||
							m_tuser !== padded_words_due[0].status)
						flag_error($sformatf("expected value %h status %0d, got value %h status %0d",
							padded_words_due[0].value, padded_words_due[0].status,
							m_tdata, m_tuser));
					void'(padded_words_due.pop_front());
				end
				recv_wait = $urandom_range(0, recv_gap_max);
			end
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				recv_wait = LONG_HOLD;
			end
			if (recv_wait > 0) begin
				recv_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_load(input logic [7:0] r, input logic [7:0] c, input logic [1:0] ch,
			input logic [31:0] w);
		pad_item_t it;
		it.op = OP_LOAD;
		it.row = r;
		it.col = c;
		it.chan = ch;
		it.word = w;
		items_to_send.push_back(it);
		if (r < MAX_H && c < MAX_W && ch < MAX_C)
			queued_written[store_index(r, c, ch)] = 1'b1;
		items_queued++;
	endtask

	// a fetch that would read a never-loaded word gets that word loaded first
	task automatic push_fetch(input logic [7:0] r, input logic [7:0] c, input logic [1:0] ch);
		pad_item_t it;
		logic [1:0] st;
		bit fill_hit;
		int addr;
		it.op = OP_FETCH;
		it.row = r;
		it.col = c;
		it.chan = ch;
		it.word = $urandom();
		map_fetch(it, st, fill_hit, addr);
		if (st == ST_OK && !fill_hit && !queued_written[addr])
			push_load(8'(addr / (MAX_W * MAX_C)), 8'((addr / MAX_C) % MAX_W),
				2'(addr % MAX_C), $urandom());
		items_to_send.push_back(it);
		items_queued++;
	endtask

	function automatic pad_cfg_t make_cfg(input int mode, input int top, input int left,
			input int height, input int width, input int chans, input logic [31:0] fill,
			input int outer);
		pad_cfg_t c;
		c.mode = 2'(mode);
		c.top = 7'(top);
		c.left = 7'(left);
		c.height = 7'(height);
		c.width = 7'(width);
		c.chans = 3'(chans);
		c.fill = fill;
		c.outer = 1'(outer);
		return c;
	endfunction

	function automatic int pick_extent();
		int r;
		r = $urandom_range(0, 31);
		if (r == 0) return $urandom_range(0, 1) ? 0 : $urandom_range(MAX_H + 1, 127);
		if (r < 5) return MAX_H;
		if (r < 10) return $urandom_range(1, MAX_H);
		return $urandom_range(1, 8);
	endfunction

	function automatic int pick_pad(input int extent);
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, 127);
		return (extent + 1 > 127) ? $urandom_range(0, 127) : $urandom_range(0, extent + 1);
	endfunction

	function automatic pad_cfg_t random_cfg();
		int mode, h, w, chans;
		mode = ($urandom_range(0, 11) == 0) ? MODE_UNSUP : $urandom_range(0, 2);
		h = pick_extent();
		w = pick_extent();
		chans = ($urandom_range(0, 15) == 0) ?
			($urandom_range(0, 1) ? 0 : $urandom_range(MAX_C + 1, 7)) : $urandom_range(1, MAX_C);
		return make_cfg(mode, pick_pad(h), pick_pad(w), h, w, chans, $urandom(),
			($urandom_range(0, 15) == 0) ? 1 : 0);
	endfunction

	// waits out all queued transfers and results, then the tail of any load in flight
	task automatic drain();
		do @(negedge clk);
		while (items_to_send.size() != 0 || s_tvalid || padded_words_due.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
	endtask

	task automatic reconfigure(input pad_cfg_t c);
		drain();
		cfg_write(CFG_PAD_MODE, 32'(c.mode));
		cfg_write(CFG_PAD_TOP, 32'(c.top));
		cfg_write(CFG_PAD_LEFT, 32'(c.left));
		cfg_write(CFG_IN_HEIGHT, 32'(c.height));
		cfg_write(CFG_IN_WIDTH, 32'(c.width));
		cfg_write(CFG_CHANNELS, 32'(c.chans));
		cfg_write(CFG_FILL_VALUE, c.fill);
		cfg_write(CFG_OUTER_PAD, 32'(c.outer));
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_cfg = c;
		@(negedge clk);
	endtask

	task automatic random_items(input int count);
		int first, h_lim, w_lim, c_lim, row_top, col_top;
		logic [1:0] ch;
		first = items_queued;
		h_lim = (cur_cfg.height >= 1 && cur_cfg.height <= MAX_H) ? cur_cfg.height : MAX_H;
		w_lim = (cur_cfg.width >= 1 && cur_cfg.width <= MAX_W) ? cur_cfg.width : MAX_W;
		c_lim = (cur_cfg.chans >= 1 && cur_cfg.chans <= MAX_C) ? cur_cfg.chans : MAX_C;
		row_top = cur_cfg.top + 2 * h_lim + 1;
		col_top = cur_cfg.left + 2 * w_lim + 1;
		if (row_top > 255) row_top = 255;
		if (col_top > 255) col_top = 255;
		while (items_queued - first < count) begin
			ch = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) :
				2'($urandom_range(0, c_lim - 1));
			if ($urandom_range(0, 4) == 0) begin
				if ($urandom_range(0, 7) == 0)
					push_load(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						2'($urandom_range(0, 3)), $urandom());
				else
					push_load(8'($urandom_range(0, h_lim - 1)), 8'($urandom_range(0, w_lim - 1)),
						ch, $urandom());
			end else if ($urandom_range(0, 7) == 0) begin
				push_fetch(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), ch);
			end else begin
				push_fetch(8'($urandom_range(0, row_top)), 8'($urandom_range(0, col_top)), ch);
			end
		end
	endtask

	initial begin
		pad_cfg_t c;
		int per_phase;
		wait (arst_n === 1'b1);
		@(negedge clk);

		// constant fill: inside, corners, far corner, ignored loads, channel out of use
		reconfigure(make_cfg(MODE_CONSTANT, 2, 3, 4, 5, 3, 32'hDEAD_BEEF, 0));
		push_load(8'd0, 8'd0, 2'd0, 32'h0000_0000);
		push_load(8'd3, 8'd4, 2'd2, 32'hFFFF_FFFF);
		push_load(8'd64, 8'd0, 2'd0, 32'h1234_5678);
		push_load(8'd0, 8'd255, 2'd1, 32'h8765_4321);
		push_load(8'd255, 8'd255, 2'd3, 32'hA5A5_5A5A);
		push_fetch(8'd2, 8'd3, 2'd0);
		push_fetch(8'd5, 8'd7, 2'd2);
		push_fetch(8'd0, 8'd0, 2'd0);
		push_fetch(8'd255, 8'd255, 2'd1);
		push_fetch(8'd3, 8'd3, 2'd3);

		// reflect: good folds on both sides and one that falls off after a fold
		reconfigure(make_cfg(MODE_REFLECT, 3, 3, 4, 4, 4, 0, 0));
		push_fetch(8'd0, 8'd0, 2'd0);
		push_fetch(8'd9, 8'd9, 2'd3);
		push_fetch(8'd10, 8'd3, 2'd0);
		push_fetch(8'd3, 8'd3, 2'd1);

		reconfigure(make_cfg(MODE_SYMMETRIC, 5, 1, 4, 2, 2, 32'hFFFF_FFFF, 0));
		push_fetch(8'd0, 8'd0, 2'd1);
		push_fetch(8'd12, 8'd3, 2'd0);
		push_fetch(8'd13, 8'd0, 2'd0);
		push_fetch(8'd1, 8'd1, 2'd2);

		// each unsupported setting on its own
		reconfigure(make_cfg(MODE_UNSUP, 0, 0, 4, 4, 4, 0, 0));
		push_fetch(8'd1, 8'd1, 2'd1);
		reconfigure(make_cfg(MODE_CONSTANT, 0, 0, 4, 4, 4, 0, 1));
		push_fetch(8'd1, 8'd1, 2'd1);
		reconfigure(make_cfg(MODE_REFLECT, 0, 0, 0, 4, 4, 0, 0));
		push_fetch(8'd1, 8'd1, 2'd1);
		reconfigure(make_cfg(MODE_SYMMETRIC, 0, 0, 4, 100, 4, 0, 0));
		push_fetch(8'd1, 8'd1, 2'd1);
		reconfigure(make_cfg(MODE_CONSTANT, 0, 0, 4, 4, 0, 0, 0));
		push_fetch(8'd1, 8'd1, 2'd0);
		reconfigure(make_cfg(MODE_CONSTANT, 0, 0, 4, 4, 7, 0, 0));
		push_fetch(8'd1, 8'd1, 2'd0);

		per_phase = 95;
		for (int ph = 0; ph < 16; ph++) begin
			case (ph)
				0: c = make_cfg(MODE_SYMMETRIC, 127, 127, MAX_H, MAX_W, MAX_C, 32'hFFFF_FFFF, 0);
				1: c = make_cfg(MODE_REFLECT, 0, 0, 1, 1, 1, 32'h0000_0000, 0);
				2: c = make_cfg(MODE_CONSTANT, 3, 2, 6, 5, 4, $urandom(), 0);
				3: c = make_cfg(MODE_REFLECT, 2, 3, 5, 6, 3, $urandom(), 0);
				default: c = random_cfg();
			endcase
			reconfigure(c);
			send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
			recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
			if (ph == 2) begin
				// receiver stalls long while the sender keeps offering back to back
				send_gap_max = 0;
				hold_requests++;
				random_items(per_phase);
			end else if (ph == 3) begin
				// sender stops until all results are back, then resumes
				random_items(per_phase / 2);
				drain();
				random_items(per_phase - per_phase / 2);
			end else begin
				random_items(per_phase);
			end
		end

		drain();
		if (mismatches == 0 && padded_words_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
